### rtl/bsrs_pkg.sv
package bsrs_pkg;

   localparam int DEPTH_DEFAULT = 256;
   localparam int VALUE_W       = 32;
   localparam int RANK_W        = 8;
   localparam int COUNT_W       = 9;
   localparam int CAP_W         = 9;
   localparam int BIT_W         = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

   typedef enum logic [1:0] {
      KIND_INSERT   = 2'd0,
      KIND_ERASE    = 2'd1,
      KIND_CONTAINS = 2'd2,
      KIND_GET      = 2'd3
   } kind_type;

   // what the datapath does with each entry read during a sweep
   typedef enum logic [1:0] {
      MODE_FIND  = 2'd0,
      MODE_SHIFT = 2'd1,
      MODE_PASS  = 2'd2
   } mode_type;

   typedef struct packed {
      logic     latch;
      logic     go;
      mode_type mode;
      logic     pass_end;
      logic     commit_insert;
      logic     commit_erase;
      logic     respond;
      logic     rsp_ok;
      logic     rsp_item;
   } cmd_type;

   typedef struct packed {
      logic found;
      logic idle;
      logic last_bit;
      logic can_insert;
      logic rank_ok;
   } status_type;

endpackage

### rtl/bsrs_ctrl.sv
module bsrs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_kind,
   input  bsrs_pkg::status_type status,
   output bsrs_pkg::cmd_type    cmd,
   output logic                 busy
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_FIND  = 6'b000010,
      ST_SHIFT = 6'b000100,
      ST_RSEL  = 6'b001000,
      ST_RANK  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   bsrs_pkg::kind_type kind_ff, kind_in;
   logic               ok_ff, ok_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= bsrs_pkg::KIND_INSERT;
         ok_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         ok_ff    <= ok_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      ok_in    = ok_ff;
      cmd      = '0;
      cmd.mode = bsrs_pkg::MODE_FIND;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               kind_in   = bsrs_pkg::kind_type'(req_kind);
               if (bsrs_pkg::kind_type'(req_kind) == bsrs_pkg::KIND_GET) begin
                  state_in = ST_RSEL;
               end else begin
                  cmd.go   = 1'b1;
                  state_in = ST_FIND;
               end
            end
         end
         ST_FIND: begin
            if (status.idle) begin
               state_in = ST_DONE;
               ok_in    = 1'b0;
               unique case (kind_ff)
                  bsrs_pkg::KIND_INSERT: begin
                     if (!status.found && status.can_insert) begin
                        cmd.commit_insert = 1'b1;
                        ok_in             = 1'b1;
                     end
                  end
                  bsrs_pkg::KIND_ERASE: begin
                     if (status.found) begin
                        cmd.go   = 1'b1;
                        cmd.mode = bsrs_pkg::MODE_SHIFT;
                        state_in = ST_SHIFT;
                     end
                  end
                  bsrs_pkg::KIND_CONTAINS: begin
                     ok_in = status.found;
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            if (status.idle) begin
               cmd.commit_erase = 1'b1;
               ok_in            = 1'b1;
               state_in         = ST_DONE;
            end
         end
         ST_RSEL: begin
            if (status.rank_ok) begin
               cmd.go   = 1'b1;
               cmd.mode = bsrs_pkg::MODE_PASS;
               state_in = ST_RANK;
            end else begin
               ok_in    = 1'b0;
               state_in = ST_DONE;
            end
         end
         ST_RANK: begin
            if (status.idle) begin
               cmd.pass_end = 1'b1;
               if (status.last_bit) begin
                  ok_in    = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  cmd.go   = 1'b1;
                  cmd.mode = bsrs_pkg::MODE_PASS;
               end
            end
         end
         ST_DONE: begin
            cmd.respond  = 1'b1;
            cmd.rsp_ok   = ok_ff;
            cmd.rsp_item = ok_ff && (kind_ff == bsrs_pkg::KIND_GET);
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### rtl/bsrs_dpath.sv
module bsrs_dpath #(
   parameter int DEPTH = bsrs_pkg::DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  bsrs_pkg::cmd_type                cmd,
   output bsrs_pkg::status_type             status,
   input  logic [bsrs_pkg::VALUE_W-1:0]     req_value,
   input  logic [bsrs_pkg::RANK_W-1:0]      req_rank,
   input  logic                             cap_we,
   input  logic [bsrs_pkg::CAP_W-1:0]       cap_data,
   output logic                             rsp_strobe,
   output logic                             rsp_ok,
   output logic [bsrs_pkg::VALUE_W-1:0]     rsp_item,
   output logic [bsrs_pkg::COUNT_W-1:0]     rsp_count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = (CW > bsrs_pkg::CAP_W) ? CW : bsrs_pkg::CAP_W;
   localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

   logic [bsrs_pkg::VALUE_W-1:0] entries_mem [DEPTH];

   logic [bsrs_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [bsrs_pkg::RANK_W-1:0]  rank_ff, rank_in;
   logic [bsrs_pkg::CAP_W-1:0]   cap_ff, cap_in;
   logic [CW-1:0]                held_ff, held_in;
   logic [CW-1:0]                rd_idx_ff, rd_idx_in;
   logic                         issue_ff, issue_in;
   bsrs_pkg::mode_type           mode_ff, mode_in;
   logic                         pv_ff, pv_in;
   logic [CW-1:0]                pa_ff, pa_in;
   logic [bsrs_pkg::VALUE_W-1:0] q_ff;
   logic                         found_ff, found_in;
   logic [CW-1:0]                pos_ff, pos_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic [bsrs_pkg::BIT_W-1:0]   bit_ff, bit_in;
   logic [bsrs_pkg::VALUE_W-1:0] pfx_ff, pfx_in;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   logic                         rsp_ok_ff, rsp_ok_in;
   logic [bsrs_pkg::VALUE_W-1:0] rsp_item_ff, rsp_item_in;
   logic [bsrs_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [bsrs_pkg::VALUE_W-1:0] trial;
   logic [LW-1:0]                cap_l, limit_l, held_l;
   logic [CW-1:0]                start_idx, rd_idx_inc;
   logic                         mem_we;
   logic [AW-1:0]                mem_wa;
   logic [bsrs_pkg::VALUE_W-1:0] mem_wd;

   assign trial      = pfx_ff | (bsrs_pkg::VALUE_W'(1) << bit_ff);
   assign cap_l      = LW'(cap_ff);
   assign held_l     = LW'(held_ff);
   assign limit_l    = (cap_l < DEPTH_L) ? cap_l : DEPTH_L;
   assign start_idx  = (cmd.mode == bsrs_pkg::MODE_SHIFT) ? pos_ff + CW'(1) : '0;
   assign rd_idx_inc = rd_idx_ff + CW'(1);

   assign status.found      = found_ff;
   assign status.idle       = !issue_ff && !pv_ff;
   assign status.last_bit   = (bit_ff == '0);
   assign status.can_insert = (held_l < limit_l);
   assign status.rank_ok    = (LW'(rank_ff) < held_l);

   // single write port: appended value or shifted entry
   always_comb begin
      mem_we = 1'b0;
      mem_wa = pa_ff[AW-1:0] - AW'(1);
      mem_wd = q_ff;
      if (cmd.commit_insert) begin
         mem_we = 1'b1;
         mem_wa = held_ff[AW-1:0];
         mem_wd = value_ff;
      end else if (pv_ff && mode_ff == bsrs_pkg::MODE_SHIFT) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entries_mem[mem_wa] <= mem_wd;
      end
      if (issue_ff) begin
         q_ff <= entries_mem[rd_idx_ff[AW-1:0]];
      end
   end

   always_comb begin
      value_in      = value_ff;
      rank_in       = rank_ff;
      cap_in        = cap_ff;
      held_in       = held_ff;
      rd_idx_in     = rd_idx_ff;
      issue_in      = issue_ff;
      mode_in       = mode_ff;
      pv_in         = issue_ff;
      pa_in         = rd_idx_ff;
      found_in      = found_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      bit_in        = bit_ff;
      pfx_in        = pfx_ff;
      rsp_strobe_in = cmd.respond;
      rsp_ok_in     = rsp_ok_ff;
      rsp_item_in   = rsp_item_ff;
      rsp_count_in  = rsp_count_ff;

      if (cap_we) begin
         cap_in = cap_data;
      end

      if (cmd.latch) begin
         value_in = req_value;
         rank_in  = req_rank;
         found_in = 1'b0;
         pfx_in   = '0;
         bit_in   = '1;
      end

      // second stage: act on the entry read last cycle
      if (pv_ff) begin
         unique case (mode_ff)
            bsrs_pkg::MODE_FIND: begin
               if (q_ff == value_ff && !found_ff) begin
                  found_in = 1'b1;
                  pos_in   = pa_ff;
               end
            end
            bsrs_pkg::MODE_PASS: begin
               if (q_ff >= trial) begin
                  cnt_in = cnt_ff + CW'(1);
               end
            end
            default: begin
            end
         endcase
      end

      // one rank pass decides one bit of the answer, msb first
      if (cmd.pass_end) begin
         if (LW'(cnt_ff) > LW'(rank_ff)) begin
            pfx_in = trial;
         end
         bit_in = bit_ff - bsrs_pkg::BIT_W'(1);
      end

      // first stage: sweep read address
      if (cmd.go) begin
         rd_idx_in = start_idx;
         issue_in  = (start_idx < held_ff);
         mode_in   = cmd.mode;
         cnt_in    = '0;
      end else if (issue_ff) begin
         rd_idx_in = rd_idx_inc;
         issue_in  = (rd_idx_inc < held_ff);
      end

      if (cmd.commit_insert) begin
         held_in = held_ff + CW'(1);
      end else if (cmd.commit_erase) begin
         held_in = held_ff - CW'(1);
      end

      if (cmd.respond) begin
         rsp_ok_in    = cmd.rsp_ok;
         rsp_item_in  = cmd.rsp_item ? pfx_ff : '0;
         rsp_count_in = bsrs_pkg::COUNT_W'(held_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= bsrs_pkg::CAP_RESET;
         held_ff       <= '0;
         issue_ff      <= 1'b0;
         pv_ff         <= 1'b0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         mode_ff       <= bsrs_pkg::MODE_FIND;
      end else begin
         cap_ff        <= cap_in;
         held_ff       <= held_in;
         issue_ff      <= issue_in;
         pv_ff         <= pv_in;
         found_ff      <= found_in;
         rsp_strobe_ff <= rsp_strobe_in;
         mode_ff       <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      rank_ff      <= rank_in;
      rd_idx_ff    <= rd_idx_in;
      pa_ff        <= pa_in;
      pos_ff       <= pos_in;
      cnt_ff       <= cnt_in;
      bit_ff       <= bit_in;
      pfx_ff       <= pfx_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_item_ff  <= rsp_item_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_ok     = rsp_ok_ff;
   assign rsp_item   = rsp_item_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

### rtl/bounded_set_with_rank_select_core.sv
// set of distinct 32-bit values kept in insertion order in a single-port-write,
// single-read ram of DEPTH words. a request is taken when start is high and
// busy is low; exactly one response follows, shown for one cycle with
// rsp_strobe high, and the receiver cannot stall it, so it must take every
// response in the cycle it appears. insert, erase and contains first sweep
// the held entries once; erase then sweeps the tail to shift it down. get
// by rank builds the answer one bit per sweep, msb first; a rank not below
// count answers without a sweep. the ram read port reads one entry per cycle
// during a sweep. the user must write capacity through the csr channel
// (always ready) only while busy is low and no response is pending; the
// block itself does not enforce this. the set never drops entries when
// capacity is lowered, it only refuses inserts.
module bounded_set_with_rank_select_core #(
   parameter int DEPTH = bsrs_pkg::DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_kind,
   input  logic [bsrs_pkg::VALUE_W-1:0]     req_value,
   input  logic [bsrs_pkg::RANK_W-1:0]      req_rank,
   // response channel
   output logic                             rsp_strobe,
   output logic                             rsp_ok,
   output logic [bsrs_pkg::VALUE_W-1:0]     rsp_item,
   output logic [bsrs_pkg::COUNT_W-1:0]     rsp_count,
   // capacity register write
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bsrs_pkg::CAP_W-1:0]       csr_data
);

   bsrs_pkg::cmd_type    cmd;
   bsrs_pkg::status_type status;
   logic                 cap_we;

   // capacity writes are always accepted: csr_ready is tied high
   assign csr_ready = 1'b1;
   assign cap_we    = csr_valid && csr_ready;

   // sequencer: picks sweeps and commits per request kind
   bsrs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // ram, sweep pipeline, counters and response registers
   bsrs_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_value  (req_value),
      .req_rank   (req_rank),
      .cap_we     (cap_we),
      .cap_data   (csr_data),
      .rsp_strobe (rsp_strobe),
      .rsp_ok     (rsp_ok),
      .rsp_item   (rsp_item),
      .rsp_count  (rsp_count)
   );

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
   import bsrs_pkg::*;

   localparam int DEPTH    = DEPTH_DEFAULT;
   localparam int POOL_N   = 24;
   localparam int PHASES   = 12;
   localparam int PHASE_N  = 84;

   typedef struct {
      kind_type             kind;
      logic [VALUE_W-1:0]   value;
      logic [RANK_W-1:0]    rank;
   } request_type;

   typedef struct {
      logic                 ok;
      logic [VALUE_W-1:0]   item;
      logic [COUNT_W-1:0]   count;
   } outcome_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [1:0]           req_kind;
   logic [VALUE_W-1:0]   req_value;
   logic [RANK_W-1:0]    req_rank;
   logic                 rsp_strobe;
   logic                 rsp_ok;
   logic [VALUE_W-1:0]   rsp_item;
   logic [COUNT_W-1:0]   rsp_count;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CAP_W-1:0]     csr_data;

   // software copy of the set, kept in insertion order
   logic [VALUE_W-1:0]   set_vals [DEPTH];
   int                   set_count;
   logic [CAP_W-1:0]     set_cap;

   outcome_type          pending_outcomes[$];
   int                   errors = 0;
   int                   sender_idle_pct = 0;

   bounded_set_with_rank_select_core #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_kind   (req_kind),
      .req_value  (req_value),
      .req_rank   (req_rank),
      .rsp_strobe (rsp_strobe),
      .rsp_ok     (rsp_ok),
      .rsp_item   (rsp_item),
      .rsp_count  (rsp_count),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // position of v among the held values, or set_count when absent
   function automatic int locate(logic [VALUE_W-1:0] v);
      for (int i = 0; i < set_count; i++)
         if (set_vals[i] == v) return i;
      return set_count;
   endfunction

   // applies one request to the software set and returns its response
   function automatic outcome_type predict_outcome(request_type r);
      outcome_type o;
      int       pos;
      int       lim;
      int       greater;
      o.ok    = 1'b0;
      o.item  = '0;
      lim     = (int'(set_cap) < DEPTH) ? int'(set_cap) : DEPTH;
      case (r.kind)
         KIND_INSERT: begin
            if (set_count < lim && locate(r.value) == set_count) begin
               set_vals[set_count] = r.value;
               set_count++;
               o.ok = 1'b1;
            end
         end
         KIND_ERASE: begin
            pos = locate(r.value);
            if (pos < set_count) begin
               // later entries slide down so insertion order survives
               for (int j = pos; j + 1 < set_count; j++)
                  set_vals[j] = set_vals[j + 1];
               set_count--;
               o.ok = 1'b1;
            end
         end
         KIND_CONTAINS: begin
            o.ok = (locate(r.value) < set_count);
         end
         default: begin
            // values are distinct, so at most one entry has this many above it
            if (int'(r.rank) < set_count) begin
               for (int j = 0; j < set_count && !o.ok; j++) begin
                  greater = 0;
                  for (int k = 0; k < set_count; k++)
                     if (set_vals[j] < set_vals[k]) greater++;
                  if (greater == int'(r.rank)) begin
                     o.item = set_vals[j];
                     o.ok   = 1'b1;
                  end
               end
            end
         end
      endcase
      o.count = set_count[COUNT_W-1:0];
      return o;
   endfunction

   // one request: optional idle gap, then hold start until the block takes it
   task automatic issue_request(input kind_type kind, input logic [VALUE_W-1:0] value,
                                input logic [RANK_W-1:0] rank);
      request_type r;
      r.kind  = kind;
      r.value = value;
      r.rank  = rank;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start     = 1'b1;
      req_kind  = kind;
      req_value = value;
      req_rank  = rank;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_outcomes.push_back(predict_outcome(r));
   endtask

   // the block stays busy after it takes a request, so dropping
   // start on the next falling edge cannot cause a stray request
   task automatic release_start;
      @(negedge clock);
      start = 1'b0;
   endtask

   // capacity changes only once every response is back
   task automatic write_capacity(input logic [CAP_W-1:0] cap_value);
      release_start();
      while (pending_outcomes.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = cap_value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      set_cap = cap_value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // response checker: every strobe must match the oldest prediction
   always @(posedge clock) begin : check_responses
      outcome_type want;
      if (!reset && rsp_strobe) begin
         if (pending_outcomes.size() == 0) begin
            errors++;
            $display("%0t: response with none expected, ok %0b item %h count %0d",
                     $time, rsp_ok, rsp_item, rsp_count);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_ok !== want.ok) begin
               errors++;
               $display("%0t: ok expected %0b actual %0b", $time, want.ok, rsp_ok);
            end
            if (rsp_item !== want.item) begin
               errors++;
               $display("%0t: item expected %h actual %h", $time, want.item, rsp_item);
            end
            if (rsp_count !== want.count) begin
               errors++;
               $display("%0t: count expected %0d actual %0d", $time, want.count, rsp_count);
            end
         end
      end
   end

   // each operation on a fresh set with the reset capacity, field extremes
   task automatic test_basic_operations;
      sender_idle_pct = 0;
      // empty set: every lookup fails
      issue_request(KIND_GET,      32'h1234_5678, 8'd0);
      issue_request(KIND_CONTAINS, 32'h0000_0000, 8'hff);
      issue_request(KIND_ERASE,    32'h0000_0000, 8'd0);
      // extremes in, duplicate refused
      issue_request(KIND_INSERT,   32'h0000_0000, 8'hff);
      issue_request(KIND_INSERT,   32'hffff_ffff, 8'd0);
      issue_request(KIND_INSERT,   32'h0000_0000, 8'd0);
      issue_request(KIND_INSERT,   32'h8000_0000, 8'd0);
      issue_request(KIND_INSERT,   32'h7fff_ffff, 8'd0);
      issue_request(KIND_CONTAINS, 32'hffff_ffff, 8'd0);
      // rank select of the largest and the smallest, then past the count
      issue_request(KIND_GET,      32'hffff_ffff, 8'd0);
      issue_request(KIND_GET,      32'h0000_0000, 8'd3);
      issue_request(KIND_GET,      32'ha5a5_a5a5, 8'd4);
      issue_request(KIND_GET,      32'h5a5a_5a5a, 8'hff);
      // erase from the middle, then again once it is gone
      issue_request(KIND_ERASE,    32'h8000_0000, 8'd0);
      issue_request(KIND_ERASE,    32'h8000_0000, 8'd0);
      issue_request(KIND_GET,      32'h0000_0000, 8'd1);
   endtask

   // capacity of zero, and capacity lowered under the current count
   task automatic test_capacity_rules;
      write_capacity('0);
      issue_request(KIND_INSERT,   32'h0000_0001, 8'd0);
      write_capacity(9'd1);
      issue_request(KIND_INSERT,   32'h0000_0001, 8'd0);
      issue_request(KIND_ERASE,    32'h0000_0000, 8'd0);
      issue_request(KIND_ERASE,    32'hffff_ffff, 8'd0);
      issue_request(KIND_INSERT,   32'h0000_0002, 8'd0);
      issue_request(KIND_ERASE,    32'h7fff_ffff, 8'd0);
      issue_request(KIND_INSERT,   32'h0000_0005, 8'd0);
      issue_request(KIND_INSERT,   32'h0000_0006, 8'd0);
   endtask

   // whole store: capacity above depth, fill, full-set queries, drain
   task automatic test_full_store;
      sender_idle_pct = 29;
      write_capacity('1);
      while (set_count < DEPTH)
         issue_request(KIND_INSERT, $urandom, 8'($urandom));
      // full: refused even with a fresh value
      issue_request(KIND_INSERT, $urandom, 8'd0);
      issue_request(KIND_GET, $urandom, 8'd0);
      issue_request(KIND_GET, $urandom, 8'hff);
      issue_request(KIND_GET, $urandom, 8'd128);
      issue_request(KIND_CONTAINS, set_vals[DEPTH - 1], 8'd0);
      // capacity exactly the depth, then one below the count
      write_capacity(9'd256);
      issue_request(KIND_INSERT, $urandom, 8'd0);
      write_capacity(9'd255);
      issue_request(KIND_ERASE, set_vals[0], 8'd0);
      issue_request(KIND_INSERT, $urandom, 8'd0);
      issue_request(KIND_ERASE, set_vals[set_count - 1], 8'd0);
      issue_request(KIND_INSERT, $urandom, 8'd0);
      // empty it again in random order so later phases stay small
      while (set_count > 0)
         issue_request(KIND_ERASE, set_vals[$urandom_range(set_count - 1, 0)], 8'($urandom));
   endtask

   // mixed traffic over a small pool of values so hits are common
   task automatic test_random_traffic;
      logic [VALUE_W-1:0] pool [POOL_N];
      logic [CAP_W-1:0]   caps [PHASES];
      logic [VALUE_W-1:0] v;
      logic [RANK_W-1:0]  rk;
      int                 pick;
      caps = '{9'd8, 9'd0, 9'd3, 9'd16, 9'd1, 9'd511,
               9'd12, 9'd256, 9'd2, 9'd20, 9'd5, 9'd10};
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 3)
            0:       sender_idle_pct = 0;
            1:       sender_idle_pct = 54;
            default: sender_idle_pct = 29;
         endcase
         write_capacity(caps[phase]);
         foreach (pool[i]) pool[i] = $urandom;
         pool[0] = (phase % 2) ? '1 : '0;
         for (int n = 0; n < PHASE_N; n++) begin
            pick = $urandom_range(99);
            v    = ($urandom_range(4) == 0) ? $urandom : pool[$urandom_range(POOL_N - 1)];
            rk   = RANK_W'($urandom);
            if (pick < 35) begin
               issue_request(KIND_INSERT, v, rk);
            end else if (pick < 55) begin
               // mostly erase something that is held, to keep the set small
               if (set_count > 0 && $urandom_range(99) < 65)
                  v = set_vals[$urandom_range(set_count - 1, 0)];
               issue_request(KIND_ERASE, v, rk);
            end else if (pick < 80) begin
               if (set_count > 0 && $urandom_range(99) < 50)
                  v = set_vals[$urandom_range(set_count - 1, 0)];
               issue_request(KIND_CONTAINS, v, rk);
            end else begin
               if (set_count > 0 && $urandom_range(99) < 80)
                  rk = RANK_W'($urandom_range(set_count - 1, 0));
               issue_request(KIND_GET, v, rk);
            end
         end
      end
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_kind  = KIND_INSERT;
      req_value = '0;
      req_rank  = '0;
      csr_valid = 1'b0;
      csr_data  = CAP_RESET;
      set_count = 0;
      set_cap   = CAP_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_operations();
      test_capacity_rules();
      test_full_store();
      test_random_traffic();

      // drain, then leave room for any stray strobe
      release_start();
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #60_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### filelist.f
rtl/bsrs_pkg.sv
rtl/bsrs_ctrl.sv
rtl/bsrs_dpath.sv
rtl/bounded_set_with_rank_select_core.sv
sim/tb.sv
